/* rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometer pressure compensation package
// Shared payload types, register indexes, status codes and arithmetic helpers.
// ----------------------------------------------------------------------------
package bpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic [1:0]         status;
  } out_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_B1_B2 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MC_MD = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OSS = 3'd5;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  localparam logic signed [27:0] B6_OFFSET = 28'sd4000;
  localparam logic [15:0]        B7_FACTOR = 16'd50000;
  localparam logic [11:0]        P_SQ_COEF = 12'd3038;
  localparam logic signed [15:0] P_LIN_COEF = -16'sd7357;
  localparam logic signed [63:0] P_OFFSET = 64'sd3791;
  localparam logic signed [63:0] B4_BIAS = 64'sd32768;
  localparam logic signed [63:0] PRESS_MAX = 64'sd262143;

  // Signed divide by 2^k, rounding toward zero
  function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] v,
                                                 input int unsigned k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage

/* rtl/barometer_pressure_compensation_core.sv */
// ----------------------------------------------------------------------------
// Barometer pressure compensation core
// Integer temperature and pressure compensation from raw sensor words.
// ----------------------------------------------------------------------------
// Usage:
//   Write the calibration words and the oversampling setting over the cfg
//   port while the core is idle. Push raw temperature / pressure pairs on the
//   input channel; each transfer yields exactly one result transfer carrying
//   temperature in tenths of a degree, pressure in pascals and a status code.
//   The result passes through 70 register stages: 9 plain stages, a
//   27-stage divider for the temperature term, a 33-stage divider for the
//   pressure quotient and the output register. Throughput is one item per
//   cycle while the receiver takes results; the pipeline advances as a
//   whole.
//   Reset clears all valid bits and the calibration registers to zero.
//   When the receiver stalls, the whole pipeline holds, in_ready_o drops,
//   and no item is lost or repeated; it resumes when the result is taken.
// ----------------------------------------------------------------------------
module barometer_pressure_compensation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bpc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bpc_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned D1NumW = 27;
  localparam int unsigned D1DenW = 18;
  localparam int unsigned D1SideW = 44;
  localparam int unsigned D2NumW = 33;
  localparam int unsigned D2DenW = 17;
  localparam int unsigned D2SideW = 18;

  logic [31:0] cal_ac1_ac2_q, cal_ac3_ac4_q, cal_ac5_ac6_q, cal_b1_b2_q, cal_mc_md_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_ac1_ac2_q <= '0;
      cal_ac3_ac4_q <= '0;
      cal_ac5_ac6_q <= '0;
      cal_b1_b2_q   <= '0;
      cal_mc_md_q   <= '0;
      oss_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpc_pkg::REG_AC1_AC2: cal_ac1_ac2_q <= cfg_wdata_i;
        bpc_pkg::REG_AC3_AC4: cal_ac3_ac4_q <= cfg_wdata_i;
        bpc_pkg::REG_AC5_AC6: cal_ac5_ac6_q <= cfg_wdata_i;
        bpc_pkg::REG_B1_B2:   cal_b1_b2_q   <= cfg_wdata_i;
        bpc_pkg::REG_MC_MD:   cal_mc_md_q   <= cfg_wdata_i;
        bpc_pkg::REG_OSS:     oss_q         <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = $signed(cal_ac1_ac2_q[31:16]);
  assign ac2 = $signed(cal_ac1_ac2_q[15:0]);
  assign ac3 = $signed(cal_ac3_ac4_q[31:16]);
  assign ac4 = cal_ac3_ac4_q[15:0];
  assign ac5 = cal_ac5_ac6_q[31:16];
  assign ac6 = cal_ac5_ac6_q[15:0];
  assign b1  = $signed(cal_b1_b2_q[31:16]);
  assign b2  = $signed(cal_b1_b2_q[15:0]);
  assign mc  = $signed(cal_mc_md_q[31:16]);
  assign md  = $signed(cal_mc_md_q[15:0]);

  logic out_valid_q;
  logic en;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: raw pressure shift, (UT - AC6) * AC5
  logic signed [16:0] s1_diff;
  logic signed [33:0] s1_prod_d, s1_prod_q;
  logic [23:0]        s1_up_d, s1_up_q;
  logic               s1_v_q;

  always_comb begin
    s1_diff   = $signed({1'b0, in_data_i.raw_temperature}) - $signed({1'b0, ac6});
    s1_prod_d = s1_diff * $signed({1'b0, ac5});
    s1_up_d   = in_data_i.raw_pressure >> (4'd8 - {2'b00, oss_q});
  end

  // Stage 2: X1, temperature divisor and operand magnitudes
  logic signed [17:0] s2_x1_d, s2_x1_q;
  logic signed [18:0] s2_den;
  logic [15:0]        s2_mc_abs;
  logic [26:0]        s2_num_d, s2_num_q;
  logic [17:0]        s2_den_d, s2_den_q;
  logic               s2_neg_d, s2_neg_q, s2_dz_d, s2_dz_q;
  logic [23:0]        s2_up_q;
  logic               s2_v_q;

  always_comb begin
    s2_x1_d   = 18'(bpc_pkg::sdiv_p2(64'(s1_prod_q), 15));
    s2_den    = 19'(s2_x1_d) + 19'(md);
    s2_mc_abs = mc[15] ? 16'(-mc) : 16'(mc);
    s2_num_d  = {s2_mc_abs, 11'b0};
    s2_den_d  = s2_den[18] ? 18'(-s2_den) : s2_den[17:0];
    s2_neg_d  = mc[15] ^ s2_den[18];
    s2_dz_d   = (s2_den == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= s1_prod_d;
      s1_up_q   <= s1_up_d;
      s2_x1_q   <= s2_x1_d;
      s2_num_q  <= s2_num_d;
      s2_den_q  <= s2_den_d;
      s2_neg_q  <= s2_neg_d;
      s2_dz_q   <= s2_dz_d;
      s2_up_q   <= s1_up_q;
    end
  end

  logic               d1_v;
  logic [D1NumW-1:0]  d1_q;
  logic [D1SideW-1:0] d1_side;

  bpc_udiv_pipe #(
    .NUM_W  (D1NumW),
    .DEN_W  (D1DenW),
    .SIDE_W (D1SideW)
  ) u_div_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .num_i   (s2_num_q),
    .den_i   (s2_den_q),
    .side_i  ({s2_up_q, s2_x1_q, s2_neg_q, s2_dz_q}),
    .valid_o (d1_v),
    .quo_o   (d1_q),
    .side_o  (d1_side)
  );

  // Stage 3: B5, temperature, B6
  logic signed [17:0] d1_x1;
  logic signed [27:0] s3_x2, s3_b5;
  logic signed [27:0] s3_b6_d, s3_b6_q;
  logic signed [15:0] s3_t_d, s3_t_q;
  logic [23:0]        s3_up_q;
  logic               s3_dz_q, s3_v_q;

  always_comb begin
    d1_x1   = $signed(d1_side[19:2]);
    s3_x2   = d1_side[1] ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});
    s3_b5   = s3_x2 + 28'(d1_x1);
    s3_t_d  = 16'(bpc_pkg::sdiv_p2(64'(s3_b5) + 64'sd8, 4));
    s3_b6_d = s3_b5 - bpc_pkg::B6_OFFSET;
  end

  // Stage 4: B6 squared and linear products
  logic signed [55:0] s4_sq_full;
  logic [54:0]        s4_sq_q;
  logic signed [43:0] s4_a2_d, s4_a2_q, s4_a3_d, s4_a3_q;
  logic signed [15:0] s4_t_q;
  logic [23:0]        s4_up_q;
  logic               s4_dz_q, s4_v_q;

  always_comb begin
    s4_sq_full = s3_b6_q * s3_b6_q;
    s4_a2_d    = ac2 * s3_b6_q;
    s4_a3_d    = ac3 * s3_b6_q;
  end

  // Stage 5: second-order terms
  logic signed [59:0] s5_m1_d, s5_m1_q, s5_m2_d, s5_m2_q;
  logic signed [43:0] s5_x2a_d, s5_x2a_q, s5_x1b_d, s5_x1b_q;
  logic signed [15:0] s5_t_q;
  logic [23:0]        s5_up_q;
  logic               s5_dz_q, s5_v_q;

  always_comb begin
    s5_m1_d  = b2 * $signed({1'b0, s4_sq_q[54:12]});
    s5_m2_d  = b1 * $signed({1'b0, s4_sq_q[54:12]});
    s5_x2a_d = 44'(bpc_pkg::sdiv_p2(64'(s4_a2_q), 11));
    s5_x1b_d = 44'(bpc_pkg::sdiv_p2(64'(s4_a3_q), 13));
  end

  // Stage 6: B3 and the B4 correction term
  logic signed [63:0] s6_x3, s6_b3w, s6_x3bw;
  logic signed [55:0] s6_b3_q;
  logic signed [47:0] s6_x3b_q;
  logic signed [15:0] s6_t_q;
  logic [23:0]        s6_up_q;
  logic               s6_dz_q, s6_v_q;

  always_comb begin
    s6_x3   = bpc_pkg::sdiv_p2(64'(s5_m1_q), 11) + 64'(s5_x2a_q);
    s6_b3w  = bpc_pkg::sdiv_p2((((64'(ac1) <<< 2) + s6_x3) <<< oss_q) + 64'sd2, 2);
    s6_x3bw = bpc_pkg::sdiv_p2(64'(s5_x1b_q) + bpc_pkg::sdiv_p2(64'(s5_m2_q), 16)
                               + 64'sd2, 2);
  end

  // Stage 7: B4 and B7
  logic signed [63:0] s7_x3s, s7_upd;
  logic [31:0]        s7_b4_prod, s7_b7_d, s7_b7_q;
  logic [15:0]        s7_b7f;
  logic [16:0]        s7_b4_d, s7_b4_q;
  logic signed [15:0] s7_t_q;
  logic               s7_zero_d, s7_zero_q, s7_v_q;

  always_comb begin
    s7_x3s     = 64'(s6_x3b_q) + bpc_pkg::B4_BIAS;
    s7_b4_prod = {16'b0, ac4} * s7_x3s[31:0];
    s7_b4_d    = s7_b4_prod[31:15];
    s7_upd     = $signed({40'b0, s6_up_q}) - 64'(s6_b3_q);
    s7_b7f     = bpc_pkg::B7_FACTOR >> oss_q;
    s7_b7_d    = s7_upd[31:0] * {16'b0, s7_b7f};
    s7_zero_d  = s6_dz_q || (s7_b4_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= d1_v;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_b6_q   <= s3_b6_d;
      s3_t_q    <= s3_t_d;
      s3_up_q   <= d1_side[43:20];
      s3_dz_q   <= d1_side[0];
      s4_sq_q   <= s4_sq_full[54:0];
      s4_a2_q   <= s4_a2_d;
      s4_a3_q   <= s4_a3_d;
      s4_t_q    <= s3_t_q;
      s4_up_q   <= s3_up_q;
      s4_dz_q   <= s3_dz_q;
      s5_m1_q   <= s5_m1_d;
      s5_m2_q   <= s5_m2_d;
      s5_x2a_q  <= s5_x2a_d;
      s5_x1b_q  <= s5_x1b_d;
      s5_t_q    <= s4_t_q;
      s5_up_q   <= s4_up_q;
      s5_dz_q   <= s4_dz_q;
      s6_b3_q   <= s6_b3w[55:0];
      s6_x3b_q  <= s6_x3bw[47:0];
      s6_t_q    <= s5_t_q;
      s6_up_q   <= s5_up_q;
      s6_dz_q   <= s5_dz_q;
      s7_b7_q   <= s7_b7_d;
      s7_b4_q   <= s7_b4_d;
      s7_t_q    <= s6_t_q;
      s7_zero_q <= s7_zero_d;
    end
  end

  logic               d2_v;
  logic [D2NumW-1:0]  d2_num;
  logic [D2NumW-1:0]  d2_q;
  logic [D2SideW-1:0] d2_side;

  assign d2_num = s7_b7_q[31] ? {1'b0, s7_b7_q} : {s7_b7_q, 1'b0};

  bpc_udiv_pipe #(
    .NUM_W  (D2NumW),
    .DEN_W  (D2DenW),
    .SIDE_W (D2SideW)
  ) u_div_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .num_i   (d2_num),
    .den_i   (s7_b4_q),
    .side_i  ({s7_t_q, !s7_b7_q[31], s7_zero_q}),
    .valid_o (d2_v),
    .quo_o   (d2_q),
    .side_o  (d2_side)
  );

  // Stage 9: pressure before correction and its products
  logic [32:0]        s9_p_d, s9_p_q;
  logic [49:0]        s9_sqp_d, s9_sqp_q;
  logic signed [48:0] s9_x2m_d, s9_x2m_q;
  logic signed [15:0] s9_t_q;
  logic               s9_zero_q, s9_v_q;

  always_comb begin
    s9_p_d   = d2_side[1] ? d2_q : {d2_q[31:0], 1'b0};
    s9_sqp_d = s9_p_d[32:8] * s9_p_d[32:8];
    s9_x2m_d = $signed({1'b0, s9_p_d}) * bpc_pkg::P_LIN_COEF;
  end

  // Stage 10: scale the quadratic and linear terms
  logic [61:0]        s10_m_d, s10_m_q;
  logic signed [32:0] s10_x2d_d, s10_x2d_q;
  logic [32:0]        s10_p_q;
  logic signed [15:0] s10_t_q;
  logic               s10_zero_q, s10_v_q;

  always_comb begin
    s10_m_d   = s9_sqp_q * 62'(bpc_pkg::P_SQ_COEF);
    s10_x2d_d = 33'(bpc_pkg::sdiv_p2(64'(s9_x2m_q), 16));
  end

  // Output stage: correction, saturation, status
  logic signed [63:0] o_x1, o_corr, o_pres;
  bpc_pkg::out_t      out_d, out_q;

  always_comb begin
    o_x1   = $signed({2'b00, s10_m_q}) >>> 16;
    o_corr = bpc_pkg::sdiv_p2(o_x1 + 64'(s10_x2d_q) + bpc_pkg::P_OFFSET, 4);
    o_pres = $signed({31'b0, s10_p_q}) + o_corr;
    out_d.temperature_tenths = s10_t_q;
    out_d.pressure_pa        = o_pres[17:0];
    out_d.status             = bpc_pkg::STATUS_OK;
    if (s10_zero_q) begin
      out_d.temperature_tenths = '0;
      out_d.pressure_pa        = '0;
      out_d.status             = bpc_pkg::STATUS_DIV_ZERO;
    end else if (o_pres > bpc_pkg::PRESS_MAX) begin
      out_d.pressure_pa = '1;
      out_d.status      = bpc_pkg::STATUS_SAT;
    end else if (o_pres < 64'sd0) begin
      out_d.pressure_pa = '0;
      out_d.status      = bpc_pkg::STATUS_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q      <= 1'b0;
      s10_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s9_v_q      <= d2_v;
      s10_v_q     <= s9_v_q;
      out_valid_q <= s10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_p_q     <= s9_p_d;
      s9_sqp_q   <= s9_sqp_d;
      s9_x2m_q   <= s9_x2m_d;
      s9_t_q     <= $signed(d2_side[17:2]);
      s9_zero_q  <= d2_side[0];
      s10_m_q    <= s10_m_d;
      s10_x2d_q  <= s10_x2d_d;
      s10_p_q    <= s9_p_q;
      s10_t_q    <= s9_t_q;
      s10_zero_q <= s9_zero_q;
      out_q      <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/bpc_udiv_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with side data.
// ----------------------------------------------------------------------------
module bpc_udiv_pipe #(
  parameter int unsigned NUM_W = 8,
  parameter int unsigned DEN_W = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_s    [NUM_W+1];
  logic [DEN_W-1:0]  rem_s  [NUM_W+1];
  logic [NUM_W-1:0]  num_s  [NUM_W+1];
  logic [NUM_W-1:0]  quo_s  [NUM_W+1];
  logic [DEN_W-1:0]  den_s  [NUM_W+1];
  logic [SIDE_W-1:0] side_s [NUM_W+1];

  assign v_s[0]    = valid_i;
  assign rem_s[0]  = '0;
  assign num_s[0]  = num_i;
  assign quo_s[0]  = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem_s[k], num_s[k][NUM_W-1]};
      diff  = trial - {1'b0, den_s[k]};
      ge    = (trial >= {1'b0, den_s[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_s[k+1]  <= {num_s[k][NUM_W-2:0], 1'b0};
        quo_s[k+1]  <= {quo_s[k][NUM_W-2:0], ge};
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = v_s[NUM_W];
  assign quo_o   = quo_s[NUM_W];
  assign side_o  = side_s[NUM_W];

endmodule

/* tb/tb_barometer_pressure_compensation_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometer pressure compensation core testbench
// Writes calibration sets over the register port, pushes raw temperature and
// pressure pairs and checks every result against a fixed value or an integer
// predictor of the compensation. Covers reset calibration, typical and extreme
// sets, all oversampling settings, zero-divisor and saturation cases, random
// idling on both sides and a long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_barometer_pressure_compensation_core;

  localparam int unsigned DrainCycles = 90;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned RandPhases = 6;

  typedef bit [31:0] cal_set_t [6];

  typedef enum int {SET_RESET, SET_TYPICAL, SET_NO_AC4} dir_set_e;

  typedef struct {
    dir_set_e       set;
    bit [15:0]      ut;
    bit [23:0]      up;
    bit             typed;
    bpc_pkg::out_t  want;
  } dir_row_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  bpc_pkg::in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  bpc_pkg::out_t  out_data_o;
  logic  cfg_we_i = 1'b0;
  logic  [bpc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic  [bpc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  bit [31:0]      cal_shadow [5];
  bit [1:0]       oss_shadow;
  bpc_pkg::out_t  expected_results [$];
  int             errors;
  int             sent;
  int             received;
  int             status_seen [4];
  bit             idle_on;
  bit             hold_req;
  int             quiet;

  barometer_pressure_compensation_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bpc_pkg::out_t compensate(bpc_pkg::in_t d);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, den, b5, b6, b3, t, corr, pres;
    bit [31:0] a4w, m, b4, b7;
    longint unsigned p;
    bpc_pkg::out_t r;
    ac1 = longint'($signed(cal_shadow[0][31:16]));
    ac2 = longint'($signed(cal_shadow[0][15:0]));
    ac3 = longint'($signed(cal_shadow[1][31:16]));
    ac4 = longint'(cal_shadow[1][15:0]);
    ac5 = longint'(cal_shadow[2][31:16]);
    ac6 = longint'(cal_shadow[2][15:0]);
    b1 = longint'($signed(cal_shadow[3][31:16]));
    b2 = longint'($signed(cal_shadow[3][15:0]));
    mc = longint'($signed(cal_shadow[4][31:16]));
    md = longint'($signed(cal_shadow[4][15:0]));
    ut = longint'(d.raw_temperature);
    up = longint'(d.raw_pressure >> (8 - oss_shadow));
    r = '0;
    r.status = bpc_pkg::STATUS_DIV_ZERO;
    x1 = ((ut - ac6) * ac5) / 32768;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = (b5 + 8) / 16;
    b6 = b5 - 4000;
    x1 = (b2 * ((b6 * b6) / 4096)) / 2048;
    x2 = (ac2 * b6) / 2048;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_shadow) + 2) / 4;
    x1 = (ac3 * b6) / 8192;
    x2 = (b1 * ((b6 * b6) / 4096)) / 65536;
    x3 = ((x1 + x2) + 2) / 4;
    a4w = 32'(ac4);
    m = 32'(x3 + 32768);
    b4 = (a4w * m) >> 15;
    if (b4 == 0) return r;
    m = 32'(up - b3);
    b7 = m * (32'd50000 >> oss_shadow);
    if (b7 < 32'h8000_0000) p = ({32'd0, b7} * 64'd2) / b4;
    else p = ({32'd0, b7 / b4}) * 64'd2;
    x1 = longint'(p / 256);
    x1 = (x1 * x1 * 3038) / 65536;
    x2 = (longint'(p) * -7357) / 65536;
    corr = (x1 + x2 + 3791) / 16;
    pres = longint'(p) + corr;
    r.status = bpc_pkg::STATUS_OK;
    if (pres > 262143) begin
      pres = 262143;
      r.status = bpc_pkg::STATUS_SAT;
    end else if (pres < 0) begin
      pres = 0;
      r.status = bpc_pkg::STATUS_SAT;
    end
    r.temperature_tenths = t[15:0];
    r.pressure_pa = pres[17:0];
    return r;
  endfunction

  function automatic cal_set_t typical_cal(bit [1:0] oss);
    cal_set_t c;
    c[bpc_pkg::REG_AC1_AC2] = 32'h0198_FFB8;
    c[bpc_pkg::REG_AC3_AC4] = 32'hC7D1_7FE5;
    c[bpc_pkg::REG_AC5_AC6] = 32'h7FF5_5A71;
    c[bpc_pkg::REG_B1_B2] = 32'h182E_0004;
    c[bpc_pkg::REG_MC_MD] = 32'hDDF9_0B34;
    c[bpc_pkg::REG_OSS] = 32'(oss);
    return c;
  endfunction

  task automatic load_cal(cal_set_t c);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[bpc_pkg::CfgIdxW-1:0];
      cfg_wdata_i <= c[i];
      @(posedge clk_i);
      if (i < 5) cal_shadow[i] = c[i];
      else oss_shadow = c[i][1:0];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send(bpc_pkg::in_t d, bit typed, bpc_pkg::out_t want);
    if (idle_on) begin
      while ($urandom_range(99) < 20) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(typed ? want : compensate(d));
    sent++;
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > StallLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet);
      $display("barometer_pressure_compensation_core: mismatch");
      $finish;
    end
  end

  task automatic check_result();
    bpc_pkg::out_t want;
    if (!(out_valid_o && out_ready_i)) return;
    received++;
    status_seen[out_data_o.status]++;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, out_data_o);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (out_data_o.temperature_tenths !== want.temperature_tenths) begin
      $display("%0t: temperature expected %0d actual %0d", $time,
               want.temperature_tenths, out_data_o.temperature_tenths);
      errors++;
    end
    if (out_data_o.pressure_pa !== want.pressure_pa) begin
      $display("%0t: pressure expected %0d actual %0d", $time,
               want.pressure_pa, out_data_o.pressure_pa);
      errors++;
    end
    if (out_data_o.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time,
               want.status, out_data_o.status);
      errors++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      check_result();
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) begin
          @(posedge clk_i);
          check_result();
        end
      end
      out_ready_i <= !idle_on || ($urandom_range(99) >= 20);
    end
  end

  initial begin
    dir_row_t rows [$];
    bpc_pkg::out_t dz;
    dir_set_e cur;
    cal_set_t c;
    bpc_pkg::in_t d;
    dz = '{temperature_tenths: '0, pressure_pa: '0, status: bpc_pkg::STATUS_DIV_ZERO};
    rows = '{
      '{SET_RESET, 16'h0000, 24'h000000, 1'b1, dz},
      '{SET_RESET, 16'hFFFF, 24'hFFFFFF, 1'b1, dz},
      '{SET_RESET, 16'h8000, 24'h800000, 1'b1, dz},
      '{SET_RESET, 16'h5A5A, 24'hA5A5A5, 1'b1, dz},
      '{SET_TYPICAL, 16'd27898, 24'h5D2300, 1'b0, dz},
      '{SET_TYPICAL, 16'h0000, 24'h000000, 1'b0, dz},
      '{SET_TYPICAL, 16'hFFFF, 24'hFFFFFF, 1'b0, dz},
      '{SET_TYPICAL, 16'h0000, 24'hFFFFFF, 1'b0, dz},
      '{SET_TYPICAL, 16'hFFFF, 24'h000000, 1'b0, dz},
      '{SET_TYPICAL, 16'h5A71, 24'h800000, 1'b0, dz},
      '{SET_TYPICAL, 16'd30000, 24'h7FFFFF, 1'b0, dz},
      '{SET_TYPICAL, 16'd20000, 24'h400000, 1'b0, dz},
      '{SET_NO_AC4, 16'd27898, 24'h5D2300, 1'b1, dz},
      '{SET_NO_AC4, 16'hFFFF, 24'hFFFFFF, 1'b1, dz},
      '{SET_NO_AC4, 16'h0000, 24'h000000, 1'b1, dz}
    };
    idle_on = 1'b1;
    cal_shadow = '{default: '0};
    oss_shadow = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur = SET_RESET;
    foreach (rows[i]) begin
      if (rows[i].set != cur) begin
        in_valid_i <= 1'b0;
        drain();
        cur = rows[i].set;
        c = typical_cal(2'd0);
        if (cur == SET_NO_AC4) c[bpc_pkg::REG_AC3_AC4][15:0] = '0;
        load_cal(c);
      end
      d.raw_temperature = rows[i].ut;
      d.raw_pressure = rows[i].up;
      send(d, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      in_valid_i <= 1'b0;
      drain();
      c = typical_cal(ph[1:0]);
      if (ph == 4) begin
        c = '{default: 32'hFFFF_FFFF};
      end else if (ph == 5) begin
        foreach (c[k]) c[k] = $urandom();
      end else begin
        for (int k = 0; k < 5; k++) c[k] ^= $urandom() & 32'h00FF_00FF;
      end
      if (ph == 3) c[bpc_pkg::REG_OSS] = 32'd3;
      load_cal(c);
      idle_on = (ph != 2);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if ($urandom_range(99) < 60) begin
          d.raw_temperature = 16'($urandom_range(36000, 20000));
        end else begin
          d.raw_temperature = 16'($urandom());
        end
        d.raw_pressure = 24'($urandom());
        send(d, 1'b0, dz);
      end
    end
    in_valid_i <= 1'b0;
    drain();

    $display("Sent %0d items over %0d calibration sets, all oversampling settings",
             sent, RandPhases + 3);
    $display("Status seen: ok %0d, divide by zero %0d, saturated %0d",
             status_seen[bpc_pkg::STATUS_OK], status_seen[bpc_pkg::STATUS_DIV_ZERO],
             status_seen[bpc_pkg::STATUS_SAT]);
    if (errors == 0 && expected_results.size() == 0 && received == sent) begin
      $display("barometer_pressure_compensation_core: match");
    end else begin
      $display("barometer_pressure_compensation_core: mismatch");
    end
    $finish;
  end

endmodule

/* barometer_pressure_compensation_core.f */
rtl/bpc_pkg.sv
rtl/bpc_udiv_pipe.sv
rtl/barometer_pressure_compensation_core.sv
tb/tb_barometer_pressure_compensation_core.sv
